// ===== hw/rtl/multi_channel_echo_ranger_defines.svh =====
// assertion macros for the echo ranger rtl
// used by mcer_ctrl and mcer_merge, expects clk and rst_n in scope
`ifndef MULTI_CHANNEL_ECHO_RANGER_DEFINES_SVH
`define MULTI_CHANNEL_ECHO_RANGER_DEFINES_SVH
`ifndef SYNTH
`define MCER_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define MCER_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define MCER_ASSERT_IMP(lbl, a, b)
`define MCER_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== hw/rtl/mcer_pkg.sv =====
// shared constants, types and helpers of the echo ranger
// no dependencies
package mcer_pkg;

    localparam int CHANNELS         = 4;
    localparam int TICK_BITS        = 20;
    localparam int ECHO_BITS        = 4;
    localparam int TMO_BITS         = 20;
    localparam int TRIG_CNT_BITS    = 4;
    localparam int TRIG_LOW_TICKS   = 2;
    localparam int TRIG_HIGH_TICKS  = 10;
    localparam int DIST_FACTOR      = 17826;
    localparam int DIST_FACTOR_BITS = 15;
    localparam int DIST_SHIFT       = 16;
    localparam int DIST_BITS        = 19;
    localparam int CHAN_BITS        = 2;
    localparam int STATUS_BITS      = 2;
    localparam int IDX_W            = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W            = (TICK_BITS > TMO_BITS) ? TICK_BITS : TMO_BITS;
    localparam int PROD_W           = TICK_BITS + DIST_FACTOR_BITS;

    localparam logic [TMO_BITS-1:0]  TMO_RESET = TMO_BITS'(30000);
    localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;

    localparam logic [STATUS_BITS-1:0] ST_MEASURED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_RISE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_TIMEOUT  = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef logic [TICK_BITS-1:0] tick_t;

    localparam tick_t TICK_MAX = '1;

    typedef struct packed {
        tick_t                  width;
        logic [STATUS_BITS-1:0] status;
    } lane_rpt_t;

    typedef struct packed {
        logic status_load;
        logic report_load;
        logic trig;
        logic busy;
    } ctrl_req_t;

    // timeout register seen in tick width (truncated or zero extended)
    function automatic tick_t to_ticks(input logic [TMO_BITS-1:0] tmo);
        logic [CMP_W-1:0] t;
        t = CMP_W'(tmo);
        return t[TICK_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/mcer_lane.sv =====
// one echo channel: rise capture and pulse width measurement
// depends on mcer_pkg
module mcer_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               meas_en,
    input  logic               clear,
    input  logic               echo,
    input  mcer_pkg::tick_t    elapsed,
    input  mcer_pkg::tick_t    tmo_ticks,
    output logic               done_next,
    output mcer_pkg::lane_rpt_t rpt
);
    import mcer_pkg::*;

    localparam logic [1:0] CS_WAIT = 2'd0;
    localparam logic [1:0] CS_HIGH = 2'd1;
    localparam logic [1:0] CS_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    tick_t      width_reg;
    tick_t      width_next;
    tick_t      rise_reg;
    tick_t      rise_next;
    tick_t      span;

    always_comb
    begin
        span       = (elapsed >= rise_reg) ? (elapsed - rise_reg) : '0;
        state_next = state_reg;
        width_next = width_reg;
        rise_next  = rise_reg;
        if (clear)
        begin
            state_next = CS_WAIT;
            width_next = '0;
        end
        else if (meas_en)
        begin
            if (state_reg == CS_WAIT && echo)
            begin
                state_next = CS_HIGH;
                rise_next  = elapsed;
            end
            else if (state_reg == CS_HIGH && !echo)
            begin
                state_next = CS_DONE;
                width_next = span + tick_t'(1);
            end
        end
    end

    // report as it would stand if this tick ends the measurement
    always_comb
    begin
        case (state_next)
            CS_DONE:
            begin
                rpt.width  = width_next;
                rpt.status = ST_MEASURED;
            end
            CS_HIGH:
            begin
                rpt.width  = tmo_ticks;
                rpt.status = ST_TIMEOUT;
            end
            default:
            begin
                rpt.width  = '0;
                rpt.status = ST_NO_RISE;
            end
        endcase
    end

    assign done_next = (state_next == CS_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_WAIT;
            width_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            width_reg <= width_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rise_reg <= rise_next;
    end

endmodule

// ===== hw/rtl/mcer_ctrl.sv =====
// sequencer: phase, trigger timing, elapsed count and timeout register
// depends on mcer_pkg and the assertion header
`include "multi_channel_echo_ranger_defines.svh"
module mcer_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           start_req,
    input  logic                           all_done,
    input  logic                           cfg_we,
    input  logic [mcer_pkg::TMO_BITS-1:0]  cfg_wdata,
    output logic                           meas_en,
    output logic                           clear,
    output mcer_pkg::tick_t                elapsed,
    output mcer_pkg::tick_t                tmo_ticks,
    output mcer_pkg::ctrl_req_t            req
);
    import mcer_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_MEAS = 2'd2;

    localparam logic [TRIG_CNT_BITS-1:0] TRIG_LOW_END =
        TRIG_CNT_BITS'(TRIG_LOW_TICKS);
    localparam logic [TRIG_CNT_BITS-1:0] TRIG_END =
        TRIG_CNT_BITS'(TRIG_LOW_TICKS + TRIG_HIGH_TICKS);

    logic [1:0]               phase_reg;
    logic [1:0]               phase_next;
    logic [TRIG_CNT_BITS-1:0] tc_reg;
    logic [TRIG_CNT_BITS-1:0] tc_next;
    tick_t                    elapsed_reg;
    tick_t                    elapsed_next;
    logic [TMO_BITS-1:0]      timeout_reg;

    logic                     is_trig;
    logic                     is_meas;
    logic                     is_idle;
    logic                     go_trig;
    logic [TRIG_CNT_BITS-1:0] tc_cur;
    logic [TRIG_CNT_BITS-1:0] tc_inc;
    logic                     trig_done;
    logic                     lvl;
    tick_t                    elapsed_inc;
    logic                     meas_end;

    always_comb
    begin
        is_trig     = (phase_reg == PH_TRIG);
        is_meas     = (phase_reg == PH_MEAS);
        is_idle     = !is_trig && !is_meas;
        go_trig     = is_trig || (is_idle && start_req);
        tc_cur      = is_idle ? '0 : tc_reg;
        tc_inc      = tc_cur + TRIG_CNT_BITS'(1);
        trig_done   = (tc_inc >= TRIG_END);
        lvl         = (tc_cur >= TRIG_LOW_END) && (tc_cur < TRIG_END);
        elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : (elapsed_reg + tick_t'(1));
        meas_end    = all_done || (CMP_W'(elapsed_inc) >= CMP_W'(timeout_reg))
                      || (elapsed_inc == TICK_MAX);

        phase_next   = phase_reg;
        tc_next      = tc_reg;
        elapsed_next = elapsed_reg;
        if (accept)
        begin
            if (go_trig)
            begin
                phase_next = trig_done ? PH_MEAS : PH_TRIG;
                tc_next    = trig_done ? '0 : tc_inc;
                if (trig_done)
                begin
                    elapsed_next = '0;
                end
            end
            else if (is_meas)
            begin
                elapsed_next = elapsed_inc;
                if (meas_end)
                begin
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    assign meas_en         = accept && is_meas;
    assign clear           = accept && go_trig && trig_done;
    assign elapsed         = elapsed_reg;
    assign tmo_ticks       = to_ticks(timeout_reg);
    assign req.report_load = accept && is_meas && meas_end;
    assign req.status_load = accept && !(is_meas && meas_end);
    assign req.trig        = go_trig && lvl;
    assign req.busy        = go_trig || is_meas;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tc_reg      <= '0;
            elapsed_reg <= '0;
            timeout_reg <= TMO_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            tc_reg      <= tc_next;
            elapsed_reg <= elapsed_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    `MCER_ASSERT_IMP(a_meas_count_cleared, phase_reg == PH_MEAS, tc_reg == '0)
    `MCER_ASSERT_NEXT(a_trig_end_resets_elapsed, clear, elapsed_reg == '0 && phase_reg == PH_MEAS)
    `MCER_ASSERT_IMP(a_trig_only_when_busy, req.trig, req.busy)

endmodule

// ===== hw/rtl/mcer_merge.sv =====
// merge stage: collects the lane reports, scales widths to distance and
// feeds the output register; depends on mcer_pkg and the assertion header
`include "multi_channel_echo_ranger_defines.svh"
module mcer_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcer_pkg::ctrl_req_t               req,
    input  mcer_pkg::lane_rpt_t               rpt [mcer_pkg::CHANNELS],
    input  logic                              out_ready,
    output logic                              in_ready,
    output logic                              out_valid,
    output logic                              kind,
    output logic                              trigger_level,
    output logic                              busy_res,
    output logic [mcer_pkg::CHAN_BITS-1:0]    channel,
    output logic [mcer_pkg::DIST_BITS-1:0]    distance,
    output logic [mcer_pkg::STATUS_BITS-1:0]  status_code,
    output logic                              last
);
    import mcer_pkg::*;

    tick_t                  rep_w_reg  [CHANNELS];
    logic [STATUS_BITS-1:0] rep_st_reg [CHANNELS];
    logic [IDX_W-1:0]       rep_idx_reg;
    logic                   rep_busy_reg;

    logic                   out_valid_reg;
    logic                   kind_reg;
    logic                   trig_reg;
    logic                   busy_reg;
    logic [CHAN_BITS-1:0]   chan_reg;
    logic [DIST_BITS-1:0]   dist_reg;
    logic [STATUS_BITS-1:0] st_reg;
    logic                   last_reg;

    logic                   out_free;
    logic                   rep_last;
    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      scaled;
    logic [DIST_BITS-1:0]   dist_sat;
    logic [IDX_W+1:0]       idx_ext;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !rep_busy_reg && out_free;
    assign rep_last = (rep_idx_reg == IDX_W'(CHANNELS - 1));

    // head of the report queue through the one distance multiplier
    always_comb
    begin
        prod     = PROD_W'(rep_w_reg[0]) * PROD_W'(DIST_FACTOR);
        scaled   = prod >> DIST_SHIFT;
        dist_sat = (scaled > PROD_W'(DIST_MAX)) ? DIST_MAX : scaled[DIST_BITS-1:0];
        idx_ext  = (IDX_W + 2)'(rep_idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_busy_reg  <= 1'b0;
            rep_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rep_busy_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
                rep_idx_reg   <= rep_idx_reg + IDX_W'(1);
                if (rep_last)
                begin
                    rep_busy_reg <= 1'b0;
                end
            end
            else if (req.status_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (req.report_load)
                begin
                    rep_busy_reg <= 1'b1;
                    rep_idx_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rep_busy_reg && out_free)
        begin
            kind_reg <= KIND_REPORT;
            trig_reg <= 1'b0;
            busy_reg <= 1'b0;
            chan_reg <= idx_ext[CHAN_BITS-1:0];
            dist_reg <= dist_sat;
            st_reg   <= rep_st_reg[0];
            last_reg <= rep_last;
            for (int i = 0; i < CHANNELS - 1; i++)
            begin
                rep_w_reg[i]  <= rep_w_reg[i+1];
                rep_st_reg[i] <= rep_st_reg[i+1];
            end
        end
        else if (req.status_load)
        begin
            kind_reg <= KIND_STATUS;
            trig_reg <= req.trig;
            busy_reg <= req.busy;
            chan_reg <= '0;
            dist_reg <= '0;
            st_reg   <= ST_MEASURED;
            last_reg <= 1'b1;
        end
        else if (req.report_load)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                rep_w_reg[i]  <= rpt[i].width;
                rep_st_reg[i] <= rpt[i].status;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign trigger_level = trig_reg;
    assign busy_res      = busy_reg;
    assign channel       = chan_reg;
    assign distance      = dist_reg;
    assign status_code   = st_reg;
    assign last          = last_reg;

    `MCER_ASSERT_IMP(a_no_request_while_draining, rep_busy_reg, !req.status_load && !req.report_load)
    `MCER_ASSERT_NEXT(a_drain_emits_report, rep_busy_reg && out_free, out_valid_reg && kind_reg == KIND_REPORT)
    `MCER_ASSERT_NEXT(a_report_load_starts_drain, req.report_load, rep_busy_reg && rep_idx_reg == '0)

endmodule

// ===== hw/rtl/multi_channel_echo_ranger.sv =====
// top level of the multichannel echo ranger: sequencer, echo lanes, merge stage
// depends on mcer_pkg, mcer_lane, mcer_ctrl, mcer_merge
//
//  port group  direction  handshake                contents
//  in          in         in_valid / in_ready      start_req, echo_levels (one tick)
//  out         out        out_valid / out_ready    kind, trigger_level, busy_res, channel,
//                                                  distance, status_code, last
//  cfg         in         cfg_we                   cfg_wdata -> timeout_ticks
//
// an ordinary tick gives one status request through the output register
// the tick that ends a measurement holds in_ready low while the per-channel reports
// leave one per cycle, when out_ready lets them, through the shared distance multiplier
// reset (async, active low) clears phase, counters, channel states; timeout returns to 30000
// out_ready low while out_valid is high holds the output register and drops in_ready
module multi_channel_echo_ranger (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              start_req,
    input  logic [mcer_pkg::ECHO_BITS-1:0]    echo_levels,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic                              trigger_level,
    output logic                              busy_res,
    output logic [mcer_pkg::CHAN_BITS-1:0]    channel,
    output logic [mcer_pkg::DIST_BITS-1:0]    distance,
    output logic [mcer_pkg::STATUS_BITS-1:0]  status_code,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [mcer_pkg::TMO_BITS-1:0]     cfg_wdata
);
    import mcer_pkg::*;

    logic              accept;
    logic              meas_en;
    logic              clear;
    tick_t             elapsed;
    tick_t             tmo_ticks;
    ctrl_req_t         req;
    logic [CHANNELS-1:0] done_vec;
    logic [CHANNELS-1:0] echo_vec;
    lane_rpt_t         rpt [CHANNELS];

    assign accept = in_valid && in_ready;

    mcer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_req (start_req),
        .all_done  (&done_vec),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .meas_en   (meas_en),
        .clear     (clear),
        .elapsed   (elapsed),
        .tmo_ticks (tmo_ticks),
        .req       (req)
    );

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        // channels past the echo field read as low
        if (i < ECHO_BITS)
        begin : g_pin
            assign echo_vec[i] = echo_levels[i];
        end
        else
        begin : g_none
            assign echo_vec[i] = 1'b0;
        end

        mcer_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .meas_en   (meas_en),
            .clear     (clear),
            .echo      (echo_vec[i]),
            .elapsed   (elapsed),
            .tmo_ticks (tmo_ticks),
            .done_next (done_vec[i]),
            .rpt       (rpt[i])
        );
    end

    mcer_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rpt           (rpt),
        .out_ready     (out_ready),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .kind          (kind),
        .trigger_level (trigger_level),
        .busy_res      (busy_res),
        .channel       (channel),
        .distance      (distance),
        .status_code   (status_code),
        .last          (last)
    );

endmodule

// ===== sim/mcer_checker.sv =====
// checker for the echo ranger: watches the tick, result and timeout register ports,
// predicts every result of each accepted tick and compares them in order
// depends on mcer_pkg
module mcer_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             start_req,
    input  logic [mcer_pkg::ECHO_BITS-1:0]   echo_levels,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             kind,
    input  logic                             trigger_level,
    input  logic                             busy_res,
    input  logic [mcer_pkg::CHAN_BITS-1:0]   channel,
    input  logic [mcer_pkg::DIST_BITS-1:0]   distance,
    input  logic [mcer_pkg::STATUS_BITS-1:0] status_code,
    input  logic                             last,
    input  logic                             cfg_we,
    input  logic [mcer_pkg::TMO_BITS-1:0]    cfg_wdata,
    output int                               mismatches,
    output int                               outstanding,
    output logic                             ranger_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    import mcer_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_MEAS} phase_e;
    typedef enum logic [1:0] {CS_WAIT, CS_HIGH, CS_DONE} lane_e;

    typedef struct {
        logic                   kind;
        logic                   trig;
        logic                   busy;
        logic [CHAN_BITS-1:0]   chan;
        logic [DIST_BITS-1:0]   dist_val;
        logic [STATUS_BITS-1:0] status;
        logic                   last;
    } ranger_result_t;

    ranger_result_t expected_results[$];

    phase_e                   phase;
    logic [TRIG_CNT_BITS-1:0] trig_count;
    tick_t                    elapsed;
    lane_e                    lane_state [CHANNELS];
    tick_t                    rise_tick  [CHANNELS];
    tick_t                    pulse_len  [CHANNELS];
    logic [TMO_BITS-1:0]      timeout_ticks;

    function automatic ranger_result_t status_result(input logic trig, input logic busy);
        ranger_result_t r;
        r.kind     = KIND_STATUS;
        r.trig     = trig;
        r.busy     = busy;
        r.chan     = '0;
        r.dist_val = '0;
        r.status   = ST_MEASURED;
        r.last     = 1'b1;
        return r;
    endfunction

    function void clear_lanes();
        for (int i = 0; i < CHANNELS; i++)
        begin
            lane_state[i] = CS_WAIT;
            rise_tick[i]  = '0;
            pulse_len[i]  = '0;
        end
    endfunction

    function void predict_tick(input logic start, input logic [ECHO_BITS-1:0] echo);
        logic           lvl;
        logic           all_done;
        logic           high;
        tick_t          w;
        logic [63:0]    dist_full;
        ranger_result_t r;
        if (phase != PH_TRIG && phase != PH_MEAS)
        begin
            phase = PH_IDLE;
            if (!start)
            begin
                expected_results.push_back(status_result(1'b0, 1'b0));
                return;
            end
            phase      = PH_TRIG;
            trig_count = '0;
        end
        if (phase == PH_TRIG)
        begin
            lvl = (trig_count >= TRIG_LOW_TICKS) &&
                  (trig_count < TRIG_LOW_TICKS + TRIG_HIGH_TICKS);
            trig_count = trig_count + 1'b1;
            if (trig_count >= TRIG_LOW_TICKS + TRIG_HIGH_TICKS)
            begin
                phase      = PH_MEAS;
                trig_count = '0;
                elapsed    = '0;
                clear_lanes();
            end
            expected_results.push_back(status_result(lvl, 1'b1));
            return;
        end
        all_done = 1'b1;
        for (int i = 0; i < CHANNELS; i++)
        begin
            high = (i < ECHO_BITS) ? echo[i] : 1'b0;
            if (lane_state[i] == CS_WAIT && high)
            begin
                lane_state[i] = CS_HIGH;
                rise_tick[i]  = elapsed;
            end
            else if (lane_state[i] == CS_HIGH && !high)
            begin
                w             = (elapsed >= rise_tick[i]) ? elapsed - rise_tick[i] : '0;
                pulse_len[i]  = w + 1'b1;
                lane_state[i] = CS_DONE;
            end
            if (lane_state[i] != CS_DONE)
                all_done = 1'b0;
        end
        if (elapsed != TICK_MAX)
            elapsed = elapsed + 1'b1;
        if (!(all_done || elapsed >= timeout_ticks || elapsed == TICK_MAX))
        begin
            expected_results.push_back(status_result(1'b0, 1'b1));
            return;
        end
        for (int i = 0; i < CHANNELS; i++)
        begin
            case (lane_state[i])
                CS_DONE:
                begin
                    r.status = ST_MEASURED;
                    w        = pulse_len[i];
                end
                CS_HIGH:
                begin
                    r.status = ST_TIMEOUT;
                    w        = to_ticks(timeout_ticks);
                end
                default:
                begin
                    r.status = ST_NO_RISE;
                    w        = '0;
                end
            endcase
            pulse_len[i] = w;
            dist_full    = (64'(w) * 64'(DIST_FACTOR)) >> DIST_SHIFT;
            r.kind       = KIND_REPORT;
            r.trig       = 1'b0;
            r.busy       = 1'b0;
            r.chan       = CHAN_BITS'(i);
            r.dist_val   = (dist_full > 64'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_BITS-1:0];
            r.last       = (i == CHANNELS - 1);
            expected_results.push_back(r);
        end
        phase = PH_IDLE;
    endfunction

    function void check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ranger_result_t want;
        if (!rst_n)
        begin
            phase         = PH_IDLE;
            trig_count    = '0;
            elapsed       = '0;
            timeout_ticks = TMO_RESET;
            clear_lanes();
            expected_results.delete();
            mismatches    = 0;
            outstanding  <= 0;
            ranger_idle  <= 1'b1;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("trigger_level", want.trig, trigger_level);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("channel", want.chan, channel);
                    check_field("distance", want.dist_val, distance);
                    check_field("status_code", want.status, status_code);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && in_ready)
                predict_tick(start_req, echo_levels);
            if (cfg_we)
                timeout_ticks = cfg_wdata;
            outstanding <= expected_results.size();
            ranger_idle <= (phase != PH_TRIG && phase != PH_MEAS);
        end
    end

endmodule

// ===== sim/multi_channel_echo_ranger_tb.sv =====
// testbench top for the echo ranger: clock, reset, tick stimulus, timeout register writes
// depends on mcer_pkg, multi_channel_echo_ranger and mcer_checker
module multi_channel_echo_ranger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcer_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   start_req;
    logic [ECHO_BITS-1:0]   echo_levels;
    logic                   out_valid;
    logic                   out_ready;
    logic                   kind;
    logic                   trigger_level;
    logic                   busy_res;
    logic [CHAN_BITS-1:0]   channel;
    logic [DIST_BITS-1:0]   distance;
    logic [STATUS_BITS-1:0] status_code;
    logic                   last;
    logic                   cfg_we;
    logic [TMO_BITS-1:0]    cfg_wdata;

    int   mismatches;
    int   outstanding;
    logic ranger_idle;

    int   send_idle_pct;
    int   rcv_idle_pct;
    int   ticks_sent;
    int   cycles;

    multi_channel_echo_ranger i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_req     (start_req),
        .echo_levels   (echo_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .trigger_level (trigger_level),
        .busy_res      (busy_res),
        .channel       (channel),
        .distance      (distance),
        .status_code   (status_code),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    mcer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_req     (start_req),
        .echo_levels   (echo_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .trigger_level (trigger_level),
        .busy_res      (busy_res),
        .channel       (channel),
        .distance      (distance),
        .status_code   (status_code),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .ranger_idle   (ranger_idle)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("multi_channel_echo_ranger test failed");
            $finish;
        end
    end

    task automatic send_tick(input logic s, input logic [ECHO_BITS-1:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_req   <= s;
        echo_levels <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // drop in_valid, then wait until the checker has seen the last accepted request and none is outstanding
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // alternate all-high and all-low echoes until the ranger is back in idle
    task automatic settle_ranger();
        wait_drained();
        while (!ranger_idle)
        begin
            send_tick(1'b0, '1);
            send_tick(1'b0, '0);
            wait_drained();
        end
    endtask

    task automatic run_sequence(input int tmo);
        int                   span;
        int                   mode;
        int                   rise_at [CHANNELS];
        int                   fall_at [CHANNELS];
        logic [ECHO_BITS-1:0] e;
        span = (tmo < 40) ? tmo + 3 : 43;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            mode        = (tmo < 40) ? $urandom_range(5) : 2;
            rise_at[ch] = $urandom_range(span - 2);
            fall_at[ch] = $urandom_range(span - 1, rise_at[ch] + 1);
            if (mode == 0)
                rise_at[ch] = 1000;
            else if (mode == 1)
                fall_at[ch] = 1000;
        end
        send_tick(1'b1, ECHO_BITS'($urandom_range(15)));
        for (int t = 1; t < TRIG_LOW_TICKS + TRIG_HIGH_TICKS; t++)
            send_tick($urandom_range(3) == 0, ECHO_BITS'($urandom_range(15)));
        for (int m = 0; m < span; m++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (m < rise_at[ch])
                    e[ch] = 1'b0;
                else if (m < fall_at[ch])
                    e[ch] = 1'b1;
                else if (m == fall_at[ch])
                    e[ch] = 1'b0;
                else
                    e[ch] = $urandom_range(1);
            end
            send_tick($urandom_range(7) == 0, e);
        end
    endtask

    task automatic run_phase(input int tmo, input int s_idle, input int r_idle,
                             input int budget);
        int   first;
        logic paused;
        settle_ranger();
        send_idle_pct = s_idle;
        rcv_idle_pct  = r_idle;
        cfg_we    <= 1'b1;
        cfg_wdata <= TMO_BITS'(tmo);
        @(posedge clk);
        cfg_we    <= 1'b0;
        first  = ticks_sent;
        paused = 1'b0;
        while (ticks_sent - first < budget)
        begin
            if ($urandom_range(4) == 0)
                send_tick($urandom_range(1), ECHO_BITS'($urandom_range(15)));
            else
                run_sequence(tmo);
            // hold the sender off once until every expected result is back
            if (!paused && ticks_sent - first >= budget / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        start_req     = 1'b0;
        echo_levels   = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        send_idle_pct = 10;
        rcv_idle_pct  = 72;
        ticks_sent    = 0;
        cycles        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle ticks, then a full cycle at the reset timeout with all lanes completing
        send_tick(1'b0, '0);
        send_tick(1'b0, '1);
        send_tick(1'b1, '0);
        for (int t = 1; t < TRIG_LOW_TICKS + TRIG_HIGH_TICKS; t++)
            send_tick(t == 3, (t % 2 == 0) ? '1 : ECHO_BITS'($urandom_range(15)));
        send_tick(1'b0, '1);
        send_tick(1'b0, 4'b1110);
        send_tick(1'b0, '0);
        send_tick(1'b0, '0);

        run_phase(1, 10, 72, 50);
        run_phase($urandom_range(40, 2), 10, 72, 50);
        run_phase(int'(TICK_MAX), 72, 10, 50);
        run_phase(0, 72, 10, 50);
        run_phase($urandom_range(40, 2), 0, 0, 50);
        run_phase($urandom_range(60, 20), 0, 0, 50);

        settle_ranger();
        repeat (CHANNELS + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("multi_channel_echo_ranger test passed");
        else
            $display("multi_channel_echo_ranger test failed");
        $finish;
    end

endmodule
